@@ src/led_blink_pattern_generator_core_defines.svh @@
// ----------------------------------------------------------------------------
// LED blink pattern generator - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define LED_BLINK_PATTERN_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbpg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbpg assertion failed");

`endif

@@ src/lbpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_pkg
// Types, register indexes, mode codes and reset values of the LED pattern
// generator.
// ----------------------------------------------------------------------------
package lbpg_pkg;

    localparam int unsigned MS_W   = 16;
    localparam int unsigned ADV_W  = 8;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned PC_W   = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE            = 3'd0;
    localparam logic [IDX_W-1:0] REG_FAST_INTERVAL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOW_INTERVAL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DOUBLE_INTERVAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_DOUBLE_PAUSE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_TRIPLE_INTERVAL = 3'd5;
    localparam logic [IDX_W-1:0] REG_TRIPLE_PAUSE    = 3'd6;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FAST   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TRIPLE = 3'd5;

    localparam logic [PC_W-1:0] DOUBLE_PULSES = 2'd2;
    localparam logic [PC_W-1:0] TRIPLE_PULSES = 2'd3;

    // Reset values
    localparam logic [MS_W-1:0] RST_FAST_INTERVAL   = 16'd100;
    localparam logic [MS_W-1:0] RST_SLOW_INTERVAL   = 16'd500;
    localparam logic [MS_W-1:0] RST_DOUBLE_INTERVAL = 16'd150;
    localparam logic [MS_W-1:0] RST_DOUBLE_PAUSE    = 16'd1000;
    localparam logic [MS_W-1:0] RST_TRIPLE_INTERVAL = 16'd150;
    localparam logic [MS_W-1:0] RST_TRIPLE_PAUSE    = 16'd1000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MS_W-1:0]   fast_interval;
        logic [MS_W-1:0]   slow_interval;
        logic [MS_W-1:0]   double_interval;
        logic [MS_W-1:0]   double_pause;
        logic [MS_W-1:0]   triple_interval;
        logic [MS_W-1:0]   triple_pause;
    } t_lbpg_cfg;

    typedef struct packed {
        logic            lit;
        logic [MS_W-1:0] elapsed_ms;
        logic [PC_W-1:0] pulse_count;
        logic            in_gap;
    } t_lbpg_state;

endpackage

@@ src/lbpg_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_cfg
// Configuration register file; flags a write that changes the mode.
// ----------------------------------------------------------------------------
module lbpg_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [lbpg_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [lbpg_pkg::MS_W-1:0]  i_cfg_wdata,
    output lbpg_pkg::t_lbpg_cfg        o_cfg,
    output logic                       o_mode_change
);
    import lbpg_pkg::*;

    t_lbpg_cfg r_cfg;

    assign o_mode_change = i_cfg_wr_en && (i_cfg_index == REG_MODE)
                           && (i_cfg_wdata[MODE_W-1:0] != r_cfg.mode);
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= MODE_OFF;
            r_cfg.fast_interval   <= RST_FAST_INTERVAL;
            r_cfg.slow_interval   <= RST_SLOW_INTERVAL;
            r_cfg.double_interval <= RST_DOUBLE_INTERVAL;
            r_cfg.double_pause    <= RST_DOUBLE_PAUSE;
            r_cfg.triple_interval <= RST_TRIPLE_INTERVAL;
            r_cfg.triple_pause    <= RST_TRIPLE_PAUSE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MODE:            r_cfg.mode            <= i_cfg_wdata[MODE_W-1:0];
                REG_FAST_INTERVAL:   r_cfg.fast_interval   <= i_cfg_wdata;
                REG_SLOW_INTERVAL:   r_cfg.slow_interval   <= i_cfg_wdata;
                REG_DOUBLE_INTERVAL: r_cfg.double_interval <= i_cfg_wdata;
                REG_DOUBLE_PAUSE:    r_cfg.double_pause    <= i_cfg_wdata;
                REG_TRIPLE_INTERVAL: r_cfg.triple_interval <= i_cfg_wdata;
                REG_TRIPLE_PAUSE:    r_cfg.triple_pause    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

@@ src/lbpg_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_step
// Next-state logic for one time advance: saturating add, interval compare,
// toggle and flash pulse bookkeeping.
// ----------------------------------------------------------------------------
module lbpg_step (
    input  lbpg_pkg::t_lbpg_cfg        i_cfg,
    input  lbpg_pkg::t_lbpg_state      i_state,
    input  logic [lbpg_pkg::ADV_W-1:0] i_advance,
    output lbpg_pkg::t_lbpg_state      o_state
);
    import lbpg_pkg::*;

    logic [MS_W:0]   sum;
    logic [MS_W-1:0] sat;
    logic [MS_W-1:0] sel_interval;
    logic [MS_W-1:0] sel_pause;
    logic [PC_W-1:0] sel_pulses;
    logic [PC_W-1:0] pc_inc;
    logic            is_blink;
    logic            is_flash;

    assign sum    = {1'b0, i_state.elapsed_ms} + {{(MS_W + 1 - ADV_W){1'b0}}, i_advance};
    assign sat    = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
    assign pc_inc = i_state.pulse_count + 2'd1;

    // Pick the timing set of the current mode.
    always_comb begin
        sel_interval = i_cfg.fast_interval;
        sel_pause    = i_cfg.double_pause;
        sel_pulses   = DOUBLE_PULSES;
        is_blink     = 1'b0;
        is_flash     = 1'b0;
        case (i_cfg.mode)
            MODE_FAST: begin
                is_blink     = 1'b1;
            end
            MODE_SLOW: begin
                sel_interval = i_cfg.slow_interval;
                is_blink     = 1'b1;
            end
            MODE_DOUBLE: begin
                sel_interval = i_cfg.double_interval;
                is_flash     = 1'b1;
            end
            MODE_TRIPLE: begin
                sel_interval = i_cfg.triple_interval;
                sel_pause    = i_cfg.triple_pause;
                sel_pulses   = TRIPLE_PULSES;
                is_flash     = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_state            = i_state;
        o_state.elapsed_ms = sat;
        if (i_cfg.mode == MODE_OFF) begin
            o_state.lit = 1'b0;
        end else if (i_cfg.mode == MODE_ON) begin
            o_state.lit = 1'b1;
        end else if (is_blink) begin
            if (sat >= sel_interval) begin
                o_state.lit        = ~i_state.lit;
                o_state.elapsed_ms = '0;
            end
        end else if (is_flash) begin
            if (i_state.in_gap) begin
                if (sat >= sel_pause) begin
                    o_state.in_gap      = 1'b0;
                    o_state.pulse_count = '0;
                    o_state.elapsed_ms  = '0;
                end
            end else if (sat >= sel_interval) begin
                o_state.lit        = ~i_state.lit;
                o_state.elapsed_ms = '0;
                // A pulse ends when the LED goes dark.
                if (i_state.lit) begin
                    o_state.pulse_count = pc_inc;
                    if (pc_inc >= sel_pulses) begin
                        o_state.in_gap = 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ src/led_blink_pattern_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pattern_generator_core
// Status LED pattern generator: off, on, fast/slow blink, double/triple flash.
// ----------------------------------------------------------------------------
// Each input item carries a time advance in milliseconds and yields exactly one
// result item with the LED level and the pause flag after that advance. The
// block takes one item per clock cycle in steady state while results are taken;
// an accepted item waits in the input register, then passes through the update
// into the result register once that register is free, and is offered there.
// The rate is set by the update of the 16-bit elapsed counter, which feeds back
// into the next item's update. The user must write configuration through the
// plain write port only while the block is idle; the block itself does not
// enforce this. Writing a new mode clears the elapsed counter, pulse count and
// pause flag but keeps the LED.
// ----------------------------------------------------------------------------
module led_blink_pattern_generator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lbpg_pkg::ADV_W-1:0]  i_advance,
    // result items
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_led_level,
    output logic                        o_pausing,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [lbpg_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [lbpg_pkg::MS_W-1:0]   i_cfg_wdata
);
    import lbpg_pkg::*;

    t_lbpg_cfg   cfg;
    logic        mode_change;
    t_lbpg_state r_state;
    t_lbpg_state n_state;

    // input register
    logic             r_in_valid;
    logic [ADV_W-1:0] r_in_advance;

    // result register
    logic r_out_valid;
    logic r_out_led;
    logic r_out_pausing;

    logic out_free;
    logic advance_item;

    // Result register is free when empty or being drained this cycle.
    assign out_free     = !r_out_valid || i_ready;
    // Move the held item through the update into the result register.
    assign advance_item = r_in_valid && out_free;
    // Take a new item whenever the input register empties this cycle.
    assign o_ready      = !r_in_valid || advance_item;

    assign o_valid     = r_out_valid;
    assign o_led_level = r_out_led;
    assign o_pausing   = r_out_pausing;

    lbpg_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_cfg         (cfg),
        .o_mode_change (mode_change)
    );

    lbpg_step u_step (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_advance (r_in_advance),
        .o_state   (n_state)
    );

    // Input register: hold the item until the update stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_advance <= i_advance;
        end
    end

    // Pattern state: a mode change clears the timing state but keeps the LED.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (mode_change) begin
            r_state.elapsed_ms  <= '0;
            r_state.pulse_count <= '0;
            r_state.in_gap      <= 1'b0;
        end else if (advance_item) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance_item) begin
            r_out_led     <= n_state.lit;
            r_out_pausing <= n_state.in_gap;
        end
    end

endmodule

@@ src/lbpg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpg_checker
// Port-level checks of the LED pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_blink_pattern_generator_core_defines.svh"

module lbpg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_led_level,
    input logic o_pausing
);

    // A stalled result stays offered and unchanged.
    `LBPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `LBPG_ASSERT_NEXT(a_out_led_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_led_level))
    `LBPG_ASSERT_NEXT(a_out_gap_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_pausing))
    // The flash pause is always dark.
    `LBPG_ASSERT_IMPL(a_pause_dark, i_clk, i_rst_n, o_valid && o_pausing, !o_led_level)
    // With no result pending, the block never refuses an item.
    `LBPG_ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, !o_valid, o_ready)

endmodule

bind led_blink_pattern_generator_core lbpg_checker u_lbpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_led_level (o_led_level),
    .o_pausing   (o_pausing)
);
